>>> rtl/hhdf_pkg.sv
// package for the http host drop filter
// holds verdict codes, protocol constants and byte helpers; no dependencies
package hhdf_pkg;

    localparam int MAX_HOST_LEN = 32;
    localparam int HOST_IDX_W   = $clog2(MAX_HOST_LEN);

    typedef enum logic [2:0] {
        CLS_MATCH    = 3'd0,
        CLS_BAD_HDR  = 3'd1,
        CLS_PORT     = 3'd2,
        CLS_SHORT    = 3'd3,
        CLS_METHOD   = 3'd4,
        CLS_NO_HOST  = 3'd5,
        CLS_HOST_BAD = 3'd6
    } verdict_t;

    typedef enum logic [2:0] {
        REG_HOST0   = 3'd0,
        REG_HOST1   = 3'd1,
        REG_HOST2   = 3'd2,
        REG_HOST3   = 3'd3,
        REG_HOSTLEN = 3'd4
    } cfg_reg_t;

    localparam logic [7:0]  TCP_PROTO = 8'd6;
    localparam logic [15:0] WEB_PORT  = 16'd80;
    localparam logic [16:0] MIN_HDR   = 17'd20;
    localparam logic [16:0] MIN_HTTP  = 17'd10;
    localparam logic [2:0]  TAG_LEN   = 3'd6;
    localparam logic [7:0]  CH_CR     = 8'h0d;
    localparam logic [7:0]  CH_LF     = 8'h0a;
    localparam logic [7:0]  CH_H      = "H";

    function automatic logic [7:0] tag_char(input logic [2:0] k);
        case (k)
            3'd0:    tag_char = "H";
            3'd1:    tag_char = "o";
            3'd2:    tag_char = "s";
            3'd3:    tag_char = "t";
            3'd4:    tag_char = ":";
            default: tag_char = " ";
        endcase
    endfunction

    function automatic logic [7:0] port_char(input logic [1:0] k);
        case (k)
            2'd0:    port_char = ":";
            2'd1:    port_char = "8";
            default: port_char = "0";
        endcase
    endfunction

    function automatic logic [7:0] get_char(input logic [2:0] k);
        case (k)
            3'd0:    get_char = "G";
            3'd1:    get_char = "E";
            3'd2:    get_char = "T";
            default: get_char = " ";
        endcase
    endfunction

    function automatic logic [7:0] post_char(input logic [2:0] k);
        case (k)
            3'd0:    post_char = "P";
            3'd1:    post_char = "O";
            3'd2:    post_char = "S";
            3'd3:    post_char = "T";
            default: post_char = " ";
        endcase
    endfunction

    function automatic logic [7:0] head_char(input logic [2:0] k);
        case (k)
            3'd0:    head_char = "H";
            3'd1:    head_char = "E";
            3'd2:    head_char = "A";
            3'd3:    head_char = "D";
            default: head_char = " ";
        endcase
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    typedef struct packed {
        logic       valid;
        logic [7:0] pkt_byte;
        logic       last_byte;
    } in_item_t;

endpackage

>>> rtl/hhdf_cfg_regs.sv
// configuration registers for the host name and its length
// depends on hhdf_pkg
module hhdf_cfg_regs
    import hhdf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    output logic [8*MAX_HOST_LEN-1:0] host_name,
    output logic [5:0]             name_len_eff
);

    logic [255:0] host_reg;
    logic [5:0]   length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_reg   <= '0;
            length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOST0:   host_reg[63:0]    <= cfg_data;
                REG_HOST1:   host_reg[127:64]  <= cfg_data;
                REG_HOST2:   host_reg[191:128] <= cfg_data;
                REG_HOST3:   host_reg[255:192] <= cfg_data;
                REG_HOSTLEN: length_reg        <= cfg_data[5:0];
                default:     ;
            endcase
        end
    end

    assign host_name    = host_reg[8*MAX_HOST_LEN-1:0];
    assign name_len_eff = (length_reg > 6'(MAX_HOST_LEN)) ? 6'(MAX_HOST_LEN) : length_reg;

endmodule

>>> rtl/hhdf_parser.sv
// per-byte packet parser and verdict logic
// depends on hhdf_pkg; takes a registered input byte, produces a registered verdict
module hhdf_parser
    import hhdf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  in_item_t                  item,
    input  logic [8*MAX_HOST_LEN-1:0] host_name,
    input  logic [5:0]                name_len_eff,
    input  logic                      res_hold,
    output logic                      res_valid,
    output verdict_t                  res_class
);

    logic [15:0] byte_index_reg, byte_index_next;
    logic [5:0]  ip_hdr_reg, ip_hdr_next;
    logic        ver_ok_reg, ver_ok_next;
    logic [15:0] total_len_reg, total_len_next;
    logic        is_tcp_reg, is_tcp_next;
    logic [15:0] dport_reg, dport_next;
    logic [5:0]  tcp_hdr_reg, tcp_hdr_next;
    logic [2:0]  meth_reg, meth_next;
    logic [2:0]  tag_reg, tag_next;
    logic [15:0] vlen_reg, vlen_next;
    logic        pre_ok_reg, pre_ok_next;
    logic        suf_ok_reg, suf_ok_next;
    logic        lf_seen_reg, lf_seen_next;
    logic        lf_match_reg, lf_match_next;
    logic        cr_seen_reg, cr_seen_next;
    logic        cr_match_reg, cr_match_next;

    logic [7:0]  b;
    logic [16:0] i17, ipl17, k17, cap17, hlen17, p17;
    logic [2:0]  k3;
    logic        vmatch;
    logic [7:0]  hbyte;
    verdict_t    cls;

    assign b      = item.pkt_byte;
    assign i17    = {1'b0, byte_index_reg};
    assign ipl17  = {11'd0, ip_hdr_reg};
    assign k17    = i17 - ipl17 - {11'd0, tcp_hdr_reg};
    assign k3     = k17[2:0];
    assign hlen17 = {11'd0, name_len_eff};
    assign p17    = {1'b0, vlen_reg};
    assign hbyte  = host_name[8*vlen_reg[HOST_IDX_W-1:0] +: 8];
    assign vmatch = pre_ok_reg && (p17 == hlen17 || (p17 == hlen17 + 17'd3 && suf_ok_reg));

    always_comb
    begin
        byte_index_next = byte_index_reg;
        ip_hdr_next     = ip_hdr_reg;
        ver_ok_next     = ver_ok_reg;
        total_len_next  = total_len_reg;
        is_tcp_next     = is_tcp_reg;
        dport_next      = dport_reg;
        tcp_hdr_next    = tcp_hdr_reg;
        meth_next       = meth_reg;
        tag_next        = tag_reg;
        vlen_next       = vlen_reg;
        pre_ok_next     = pre_ok_reg;
        suf_ok_next     = suf_ok_reg;
        lf_seen_next    = lf_seen_reg;
        lf_match_next   = lf_match_reg;
        cr_seen_next    = cr_seen_reg;
        cr_match_next   = cr_match_reg;
        if (byte_index_reg < 16'd4 || byte_index_reg < total_len_reg)
        begin
            if (byte_index_reg == 16'd0)
            begin
                ver_ok_next = b[7:4] == 4'd4;
                ip_hdr_next = {b[3:0], 2'b00};
            end
            else if (byte_index_reg == 16'd2)
                total_len_next = {b, total_len_reg[7:0]};
            else if (byte_index_reg == 16'd3)
                total_len_next = {total_len_reg[15:8], b};
            if (byte_index_reg == 16'd9)
                is_tcp_next = b == TCP_PROTO;
            if (byte_index_reg != 16'd0)
            begin
                if (i17 == ipl17 + 17'd2)
                    dport_next = {b, dport_reg[7:0]};
                if (i17 == ipl17 + 17'd3)
                    dport_next = {dport_reg[15:8], b};
                if (i17 == ipl17 + 17'd12)
                    tcp_hdr_next = {b[7:4], 2'b00};
                else if ({11'd0, tcp_hdr_reg} >= MIN_HDR
                         && i17 >= ipl17 + {11'd0, tcp_hdr_reg})
                begin
                    if (k17 < 17'd5)
                    begin
                        if (k17 < 17'd4 && b != get_char(k3))
                            meth_next[0] = 1'b0;
                        if (b != post_char(k3))
                            meth_next[1] = 1'b0;
                        if (b != head_char(k3))
                            meth_next[2] = 1'b0;
                    end
                    if (tag_reg < TAG_LEN)
                    begin
                        if (b == tag_char(tag_reg))
                            tag_next = tag_reg + 3'd1;
                        else
                            tag_next = (b == CH_H) ? 3'd1 : 3'd0;
                    end
                    else if (!cr_seen_reg)
                    begin
                        if (b == CH_CR)
                        begin
                            cr_seen_next  = 1'b1;
                            cr_match_next = vmatch;
                        end
                        else
                        begin
                            if (b == CH_LF && !lf_seen_reg)
                            begin
                                lf_seen_next  = 1'b1;
                                lf_match_next = vmatch;
                            end
                            if (p17 < hlen17)
                            begin
                                if (fold(b) != fold(hbyte))
                                    pre_ok_next = 1'b0;
                            end
                            else if (p17 < hlen17 + 17'd3)
                            begin
                                if (b != port_char(2'(p17 - hlen17)))
                                    suf_ok_next = 1'b0;
                            end
                            if (vlen_reg != 16'hffff)
                                vlen_next = vlen_reg + 16'd1;
                        end
                    end
                end
            end
        end
        if (byte_index_reg != 16'hffff)
            byte_index_next = byte_index_reg + 16'd1;
    end

    // verdict from state after this byte
    always_comb
    begin
        logic [16:0] len, tl, iplx, tcplx;
        len   = {1'b0, byte_index_next};
        tl    = {1'b0, total_len_next};
        iplx  = {11'd0, ip_hdr_next};
        tcplx = {11'd0, tcp_hdr_next};
        cap17 = (len < tl) ? len : tl;
        if (len < MIN_HDR)
            cls = CLS_BAD_HDR;
        else if (!ver_ok_next || iplx < MIN_HDR || cap17 < iplx + MIN_HDR || !is_tcp_next)
            cls = CLS_BAD_HDR;
        else if (tcplx < MIN_HDR || cap17 < iplx + tcplx)
            cls = CLS_BAD_HDR;
        else if (dport_next != WEB_PORT)
            cls = CLS_PORT;
        else if (cap17 - iplx - tcplx < MIN_HTTP)
            cls = CLS_SHORT;
        else if (meth_next == 3'd0)
            cls = CLS_METHOD;
        else if (tag_next < TAG_LEN || (!cr_seen_next && !lf_seen_next))
            cls = CLS_NO_HOST;
        else if (cr_seen_next ? cr_match_next : lf_match_next)
            cls = CLS_MATCH;
        else
            cls = CLS_HOST_BAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            ip_hdr_reg     <= '0;
            ver_ok_reg     <= 1'b0;
            total_len_reg  <= '0;
            is_tcp_reg     <= 1'b0;
            dport_reg      <= '0;
            tcp_hdr_reg    <= '0;
            meth_reg       <= 3'b111;
            tag_reg        <= '0;
            vlen_reg       <= '0;
            pre_ok_reg     <= 1'b1;
            suf_ok_reg     <= 1'b1;
            lf_seen_reg    <= 1'b0;
            lf_match_reg   <= 1'b0;
            cr_seen_reg    <= 1'b0;
            cr_match_reg   <= 1'b0;
            res_valid      <= 1'b0;
            res_class      <= CLS_MATCH;
        end
        else
        begin
            // a held verdict stays until the output register takes it
            if (!(res_valid && res_hold))
            begin
                res_valid <= item.valid && item.last_byte;
                if (item.valid)
                    res_class <= cls;
            end
            if (item.valid)
            begin
                if (item.last_byte)
                begin
                    byte_index_reg <= '0;
                    ip_hdr_reg     <= '0;
                    ver_ok_reg     <= 1'b0;
                    total_len_reg  <= '0;
                    is_tcp_reg     <= 1'b0;
                    dport_reg      <= '0;
                    tcp_hdr_reg    <= '0;
                    meth_reg       <= 3'b111;
                    tag_reg        <= '0;
                    vlen_reg       <= '0;
                    pre_ok_reg     <= 1'b1;
                    suf_ok_reg     <= 1'b1;
                    lf_seen_reg    <= 1'b0;
                    lf_match_reg   <= 1'b0;
                    cr_seen_reg    <= 1'b0;
                    cr_match_reg   <= 1'b0;
                end
                else
                begin
                    byte_index_reg <= byte_index_next;
                    ip_hdr_reg     <= ip_hdr_next;
                    ver_ok_reg     <= ver_ok_next;
                    total_len_reg  <= total_len_next;
                    is_tcp_reg     <= is_tcp_next;
                    dport_reg      <= dport_next;
                    tcp_hdr_reg    <= tcp_hdr_next;
                    meth_reg       <= meth_next;
                    tag_reg        <= tag_next;
                    vlen_reg       <= vlen_next;
                    pre_ok_reg     <= pre_ok_next;
                    suf_ok_reg     <= suf_ok_next;
                    lf_seen_reg    <= lf_seen_next;
                    lf_match_reg   <= lf_match_next;
                    cr_seen_reg    <= cr_seen_next;
                    cr_match_reg   <= cr_match_next;
                end
            end
        end
    end

    a_method_only_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && !item.last_byte) |=> ((meth_reg & ~$past(meth_reg)) == 3'd0))
        else $error("method flag set mid packet");
    a_cr_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (cr_seen_reg && item.valid && !item.last_byte) |=> cr_seen_reg)
        else $error("cr end lost mid packet");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.last_byte) |=> (byte_index_reg == 16'd0 && meth_reg == 3'b111))
        else $error("packet state not cleared");

endmodule

>>> rtl/http_host_drop_filter.sv
// Top level of the http host drop filter: one verdict per packet, one byte per cycle.
// Each byte is registered, parsed by short compare logic into a result register,
// and the verdict then moves to the output register. Bytes that are not last leave
// the input register every cycle; a last byte waits there, and in_stall holds new
// bytes, only while the result register and a stalled output register both hold
// verdicts.
// depends on hhdf_pkg, hhdf_cfg_regs, hhdf_parser
module http_host_drop_filter
    import hhdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pkt_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        drop,
    output logic [2:0]  verdict_class
);

    logic [8*MAX_HOST_LEN-1:0] host_name;
    logic [5:0]                name_len_eff;
    in_item_t                  in_reg;
    in_item_t                  par_item;
    logic                      res_valid;
    verdict_t                  res_class;
    logic                      out_valid_reg;
    verdict_t                  out_class_reg;
    logic                      full;

    // stall only a last byte that has nowhere to put its verdict
    assign full     = out_valid_reg && out_stall;
    assign in_stall = full && res_valid && in_reg.valid && in_reg.last_byte;

    hhdf_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .host_name    (host_name),
        .name_len_eff (name_len_eff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg <= '0;
        else if (!in_stall)
        begin
            in_reg.valid     <= in_valid;
            in_reg.pkt_byte  <= pkt_byte;
            in_reg.last_byte <= last_byte;
        end
    end

    assign par_item = '{valid: in_reg.valid && !in_stall,
                        pkt_byte: in_reg.pkt_byte, last_byte: in_reg.last_byte};

    hhdf_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (par_item),
        .host_name    (host_name),
        .name_len_eff (name_len_eff),
        .res_hold     (full),
        .res_valid    (res_valid),
        .res_class    (res_class)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_class_reg <= CLS_MATCH;
        end
        else if (!full)
        begin
            out_valid_reg <= res_valid;
            out_class_reg <= res_class;
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict_class = out_class_reg;
    assign drop          = out_class_reg == CLS_MATCH;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(verdict_class)))
        else $error("held verdict changed");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && res_valid) |=> (res_valid && $stable(res_class)))
        else $error("held result changed");
    a_stall_last_only: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_reg.valid && in_reg.last_byte))
        else $error("stall without a waiting last byte");
    a_drop_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drop == (verdict_class == CLS_MATCH)))
        else $error("drop and class disagree");

endmodule

>>> test/http_host_drop_filter_chk.sv
// checker for the http host drop filter: watches config writes and both channels,
// predicts each packet verdict and compares it with the block output; uses hhdf_pkg
module http_host_drop_filter_chk
    import hhdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  pkt_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        drop,
    input  logic [2:0]  verdict_class,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic     drop;
        verdict_t cls;
    } verdict_rec_t;

    verdict_rec_t verdicts_due[$];

    logic [63:0] host_regs [4];
    int          name_len;

    int byte_cnt, ip_hlen, ip_tlen, dport, tcp_hlen, meth_flags, tag_pos, val_len;
    bit ver_ok, tcp_ok, prefix_ok, port_ok, lf_seen, lf_hit, cr_seen, cr_hit;

    bit [7:0] tag_txt  [6] = '{"H", "o", "s", "t", ":", " "};
    bit [7:0] port_txt [3] = '{":", "8", "0"};
    bit [7:0] get_txt  [4] = '{"G", "E", "T", " "};
    bit [7:0] post_txt [5] = '{"P", "O", "S", "T", " "};
    bit [7:0] head_txt [5] = '{"H", "E", "A", "D", " "};

    function automatic bit [7:0] lower(bit [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic int eff_len();
        return name_len > MAX_HOST_LEN ? MAX_HOST_LEN : name_len;
    endfunction

    function automatic bit [7:0] host_at(int q);
        q = q & 31;
        return host_regs[q >> 3][(q & 7) * 8 +: 8];
    endfunction

    function automatic bit host_ok();
        if (!prefix_ok)
            return 0;
        return val_len == eff_len() || (val_len == eff_len() + 3 && port_ok);
    endfunction

    task automatic clear_pkt();
        byte_cnt = 0; ip_hlen = 0; ver_ok = 0; ip_tlen = 0; tcp_ok = 0; dport = 0;
        tcp_hlen = 0; meth_flags = 7; tag_pos = 0; val_len = 0; prefix_ok = 1;
        port_ok = 1; lf_seen = 0; lf_hit = 0; cr_seen = 0; cr_hit = 0;
    endtask

    task automatic value_byte(bit [7:0] b);
        int len;
        len = eff_len();
        if (val_len < len)
        begin
            if (lower(b) != lower(host_at(val_len)))
                prefix_ok = 0;
        end
        else if (val_len < len + 3)
        begin
            if (b != port_txt[val_len - len])
                port_ok = 0;
        end
        if (val_len < 65535)
            val_len++;
    endtask

    task automatic http_byte(int k, bit [7:0] b);
        if (k < 5)
        begin
            if (k < 4 && b != get_txt[k])
                meth_flags &= ~1;
            if (b != post_txt[k])
                meth_flags &= ~2;
            if (b != head_txt[k])
                meth_flags &= ~4;
        end
        if (tag_pos < TAG_LEN)
        begin
            if (b == tag_txt[tag_pos])
                tag_pos++;
            else
                tag_pos = (b == CH_H) ? 1 : 0;
            return;
        end
        if (cr_seen)
            return;
        if (b == CH_CR)
        begin
            cr_seen = 1;
            cr_hit = host_ok();
            return;
        end
        if (b == CH_LF && !lf_seen)
        begin
            lf_seen = 1;
            lf_hit = host_ok();
        end
        value_byte(b);
    endtask

    function automatic verdict_t classify();
        int cap;
        cap = byte_cnt < ip_tlen ? byte_cnt : ip_tlen;
        if (byte_cnt < MIN_HDR)
            return CLS_BAD_HDR;
        if (!ver_ok || ip_hlen < MIN_HDR || cap < ip_hlen + MIN_HDR || !tcp_ok)
            return CLS_BAD_HDR;
        if (tcp_hlen < MIN_HDR || cap < ip_hlen + tcp_hlen)
            return CLS_BAD_HDR;
        if (dport != WEB_PORT)
            return CLS_PORT;
        if (cap - ip_hlen - tcp_hlen < MIN_HTTP)
            return CLS_SHORT;
        if (meth_flags == 0)
            return CLS_METHOD;
        if (tag_pos < TAG_LEN || (!cr_seen && !lf_seen))
            return CLS_NO_HOST;
        if (cr_seen ? cr_hit : lf_hit)
            return CLS_MATCH;
        return CLS_HOST_BAD;
    endfunction

    task automatic take_byte(bit [7:0] b, bit last);
        int i, hl;
        verdict_rec_t v;
        i = byte_cnt;
        if (i < 4 || i < ip_tlen)
        begin
            hl = ip_hlen;
            if (i == 0)
            begin
                ver_ok = b[7:4] == 4'd4;
                ip_hlen = b[3:0] * 4;
            end
            else if (i == 2)
                ip_tlen = (ip_tlen & 8'hff) | (b << 8);
            else if (i == 3)
                ip_tlen = (ip_tlen & 16'hff00) | b;
            if (i == 9)
                tcp_ok = b == TCP_PROTO;
            if (i != 0)
            begin
                if (i == hl + 2)
                    dport = (dport & 8'hff) | (b << 8);
                if (i == hl + 3)
                    dport = (dport & 16'hff00) | b;
                if (i == hl + 12)
                    tcp_hlen = b[7:4] * 4;
                else if (tcp_hlen >= MIN_HDR && i >= hl + tcp_hlen)
                    http_byte(i - hl - tcp_hlen, b);
            end
        end
        if (i < 65535)
            byte_cnt = i + 1;
        if (last)
        begin
            v.cls = classify();
            v.drop = v.cls == CLS_MATCH;
            verdicts_due.push_back(v);
            clear_pkt();
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_rec_t v;
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
                host_regs[r] = '0;
            name_len = 0;
            clear_pkt();
            verdicts_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                    report("unexpected verdict class", verdict_class, -1);
                else
                begin
                    v = verdicts_due.pop_front();
                    if (drop !== v.drop)
                        report("drop", drop, v.drop);
                    if (verdict_class !== v.cls)
                        report("verdict_class", verdict_class, v.cls);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOST0:   host_regs[0] = cfg_data;
                    REG_HOST1:   host_regs[1] = cfg_data;
                    REG_HOST2:   host_regs[2] = cfg_data;
                    REG_HOST3:   host_regs[3] = cfg_data;
                    REG_HOSTLEN: name_len = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                take_byte(pkt_byte, last_byte);
            pending = verdicts_due.size();
        end
    end

endmodule

>>> test/http_host_drop_filter_tb.sv
// testbench top for the http host drop filter: clock, reset, config phases and
// packet stimulus with random gaps and stalls; verdicts are checked by http_host_drop_filter_chk
module http_host_drop_filter_tb;
    import hhdf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [7:0]  pkt_byte = '0;
    logic        last_byte = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        drop;
    logic [2:0]  verdict_class;
    int          errors;
    int          pending;

    logic [63:0] host_cfg [4];
    int          name_len;
    bit   [7:0]  pk [$];
    int          burst_left = 0;
    int          bytes_sent = 0;
    bit          hold_req = 0;

    http_host_drop_filter dut (.*);
    http_host_drop_filter_chk chk (.*);

    always #4 clk = ~clk;

    initial
    begin
        #1ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int mode, cnt;
        mode = 0;
        cnt = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1;
                repeat (400) @(negedge clk);
                hold_req = 0;
            end
            else
            begin
                if (cnt == 0)
                begin
                    mode = $urandom_range(0, 3);
                    cnt = $urandom_range(16, 96);
                end
                cnt--;
                case (mode)
                    0: out_stall <= 0;
                    1: out_stall <= $urandom_range(0, 99) < 30;
                    2: out_stall <= $urandom_range(0, 99) < 75;
                    default: out_stall <= cnt[2];
                endcase
            end
        end
    end

    task automatic cfg_write(cfg_reg_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic set_host(int len, bit with_zero);
        bit [7:0] c;
        for (int q = 0; q < 32; q++)
        begin
            case ($urandom_range(0, 5))
                0: c = $urandom_range("0", "9");
                1: c = ($urandom_range(0, 1)) ? "." : "-";
                2: c = $urandom_range(0, 255);
                default: c = $urandom_range("a", "z");
            endcase
            host_cfg[q >> 3][(q & 7) * 8 +: 8] = c;
        end
        if (with_zero)
            host_cfg[0][$urandom_range(0, 3) * 8 +: 8] = 8'h00;
        name_len = len;
        cfg_write(REG_HOST0, host_cfg[0]);
        cfg_write(REG_HOST1, host_cfg[1]);
        cfg_write(REG_HOST2, host_cfg[2]);
        cfg_write(REG_HOST3, host_cfg[3]);
        cfg_write(REG_HOSTLEN, 64'(len));
    endtask

    task automatic push_str(string s);
        for (int k = 0; k < s.len(); k++)
            pk.push_back(s[k]);
    endtask

    task automatic push_rand(int n);
        repeat (n) pk.push_back($urandom_range(0, 255));
    endtask

    // meth: 0 get, 1 post, 2 head, 3 other, 4 too short
    // hv: 0 exact, 1 mixed case, 2 with :80, 3 wrong byte, 4 no tag, 5 lf only,
    //     6 no line end, 7 bad port suffix
    // tl: 0 exact length, 1 trailing bytes past length, 2 length cut short
    task automatic build_pkt(int meth, int hv, bit port_ok, bit opts, int tl);
        int e, n, bad;
        bit [7:0] c;
        pk.delete();
        pk.push_back({4'd4, opts ? 4'd6 : 4'd5});
        push_rand(3);
        push_rand(5);
        pk.push_back(TCP_PROTO);
        push_rand(10);
        if (opts)
            push_rand(4);
        push_rand(2);
        if (port_ok)
        begin
            pk.push_back(8'd0);
            pk.push_back(8'd80);
        end
        else
            push_rand(2);
        push_rand(8);
        pk.push_back({opts ? 4'd6 : 4'd5, 4'($urandom_range(0, 15))});
        push_rand(7);
        if (opts)
            push_rand(4);
        case (meth)
            0: push_str("GET ");
            1: push_str("POST ");
            2: push_str("HEAD ");
            3: push_str("PUT ");
            default: push_str("GET /");
        endcase
        if (meth != 4)
        begin
            push_str("/ HTTP/1.1\r\n");
            if ($urandom_range(0, 2) == 0)
                push_str("Accept: */*\r\n");
            push_str(hv == 4 ? "host: " : "Host: ");
            e = name_len > 32 ? 32 : name_len;
            bad = $urandom_range(0, e > 0 ? e - 1 : 0);
            for (int q = 0; q < e; q++)
            begin
                c = host_cfg[q >> 3][(q & 7) * 8 +: 8];
                if (hv == 1 && c >= "a" && c <= "z" && $urandom_range(0, 1))
                    c = c - 8'd32;
                if (hv == 3 && q == bad)
                    c = c ^ 8'h01;
                pk.push_back(c);
            end
            if (hv == 3 && e == 0)
                push_str("x");
            if (hv == 2)
                push_str(":80");
            if (hv == 7)
                push_str(":81");
            if (hv == 5)
                push_str("\n\n");
            else if (hv != 6)
                push_str("\r\n\r\n");
        end
        n = pk.size();
        if (tl == 2)
            n = $urandom_range(0, n);
        pk[2] = n[15:8];
        pk[3] = n[7:0];
        if (tl == 1)
            push_rand($urandom_range(1, 6));
    endtask

    task automatic send_byte(bit [7:0] b, bit l);
        @(negedge clk);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1;
        pkt_byte <= b;
        last_byte <= l;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_pkt();
        for (int k = 0; k < pk.size(); k++)
            send_byte(pk[k], k == pk.size() - 1);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic rand_pkt();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            pk.delete();
            push_rand($urandom_range(1, 48));
            if ($urandom_range(0, 1))
                pk[0] = 8'h45;
        end
        else
        begin
            build_pkt($urandom_range(0, 99) < 85 ? $urandom_range(0, 2) : $urandom_range(3, 4),
                      $urandom_range(0, 7), $urandom_range(0, 9) != 0,
                      $urandom_range(0, 4) == 0,
                      $urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 2));
            if (sel < 30)
                pk[$urandom_range(0, pk.size() - 1)] = $urandom_range(0, 255);
        end
        send_pkt();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed packets
        set_host(11, 0);
        for (int m = 0; m < 5; m++)
        begin
            build_pkt(m, 0, 1, 0, 0);
            send_pkt();
        end
        for (int h = 1; h < 8; h++)
        begin
            build_pkt(0, h, 1, h == 2, 0);
            send_pkt();
        end
        build_pkt(1, 0, 0, 0, 0);
        send_pkt();
        build_pkt(2, 0, 1, 0, 1);
        send_pkt();
        build_pkt(0, 0, 1, 0, 2);
        send_pkt();
        pk.delete();
        pk.push_back(8'hff);
        send_pkt();
        pk.delete();
        push_rand(3);
        send_pkt();
        settle();

        set_host(0, 0);
        build_pkt(0, 0, 1, 0, 0);
        send_pkt();
        build_pkt(0, 2, 1, 0, 0);
        send_pkt();
        settle();

        // random phases
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                2: set_host(32, 1);
                3: set_host($urandom_range(33, 63), 0);
                default: set_host($urandom_range(1, 12), $urandom_range(0, 3) == 0);
            endcase
            if (ph == 1)
            begin
                hold_req = 1;
                while (hold_req)
                begin
                    pk.delete();
                    push_rand($urandom_range(1, 3));
                    send_pkt();
                end
            end
            rand_pkt();
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
